### rtl/hbf_pkg.sv
// hbf_pkg: shared types and constants for the harmonic bond force unit
`default_nettype none
package hbf_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_BOX_X  = 3'd0;
  localparam logic [2:0] CFG_BOX_Y  = 3'd1;
  localparam logic [2:0] CFG_BOX_Z  = 3'd2;
  localparam logic [2:0] CFG_K0     = 3'd3;
  localparam logic [2:0] CFG_R0_0   = 3'd4;
  localparam logic [2:0] CFG_K1     = 3'd5;
  localparam logic [2:0] CFG_R0_1   = 3'd6;

  // pipeline layout
  localparam int SQ_FIRST  = 4;             // first root iteration stage
  localparam int SQ_STEPS  = 32;
  localparam int ERR_STG   = SQ_FIRST + SQ_STEPS;   // length error, divide init
  localparam int DIV_FIRST = ERR_STG + 1;
  localparam int DIV_STEPS = 32;
  localparam int MUL_STG   = DIV_FIRST + DIV_STEPS;
  localparam int FRC_STG   = MUL_STG + 1;
  localparam int NST       = FRC_STG + 1;

  typedef struct packed {
    logic              vld;
    logic              kind;
    logic [2:0][33:0]  diff;
    logic [2:0][31:0]  d;
    logic [2:0][31:0]  mag;
    logic [2:0][63:0]  sq;
    logic [63:0]       rem;
    logic [63:0]       root;
    logic [31:0]       r;
    logic              eneg;
    logic [31:0]       eabs;
    logic [63:0]       prod;
    logic [2:0][32:0]  drem;
    logic [2:0][32:0]  u;
    logic [2:0][48:0]  phi;
    logic [2:0][64:0]  plo;
    logic [2:0][31:0]  frc;
    logic              sat;
    logic              zl;
  } stage_t;

  typedef struct packed {
    logic [2:0][31:0] frc;
    logic [2:0][31:0] sep;
    logic [31:0]      rlen;
    logic             zl;
    logic             sat;
  } out_t;

endpackage
`default_nettype wire

### rtl/harmonic_bond_force_unit.sv
// harmonic_bond_force_unit: pipelined harmonic bond force with minimum image wrap
//
//   channel | direction | ports                        | moves
//   in_     | input     | in_valid / in_ready          | one bond per beat
//   out_    | output    | out_valid / out_ready        | one force result per beat
//   cfg_    | input     | cfg_we, cfg_index, cfg_wdata | one register write per beat
//
// one bond enters per cycle while the skid stage is free
// the pipeline holds the 32 root iterations and 33 quotient steps, one per stage
// bonds whose first index is not below the second leave no result
// reset clears valid bits and loads the register reset values, no clearing pass
// a stall at the output fills a skid stage, then freezes the whole pipeline
`default_nettype none
module harmonic_bond_force_unit #(
  parameter int BOND_KINDS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_first_index,
  input  wire logic [23:0] in_second_index,
  input  wire logic [31:0] in_first_pos_x,
  input  wire logic [31:0] in_first_pos_y,
  input  wire logic [31:0] in_first_pos_z,
  input  wire logic [31:0] in_second_pos_x,
  input  wire logic [31:0] in_second_pos_y,
  input  wire logic [31:0] in_second_pos_z,
  input  wire logic [0:0]  in_bond_kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_force_x,
  output logic [31:0]      out_force_y,
  output logic [31:0]      out_force_z,
  output logic [31:0]      out_sep_x,
  output logic [31:0]      out_sep_y,
  output logic [31:0]      out_sep_z,
  output logic [31:0]      out_distance,
  output logic             out_zero_length,
  output logic             out_saturated,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import hbf_pkg::*;

  // configuration registers
  logic [2:0][30:0] box_r;
  logic [31:0]      k0_r, k1_r;
  logic [30:0]      r00_r, r01_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= {3{31'd65536}};
      k0_r  <= 32'd0;
      k1_r  <= 32'd0;
      r00_r <= 31'd65536;
      r01_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X: box_r[0] <= cfg_wdata[30:0];
        CFG_BOX_Y: box_r[1] <= cfg_wdata[30:0];
        CFG_BOX_Z: box_r[2] <= cfg_wdata[30:0];
        CFG_K0:    k0_r     <= cfg_wdata;
        CFG_R0_0:  r00_r    <= cfg_wdata[30:0];
        CFG_K1:    k1_r     <= cfg_wdata;
        CFG_R0_1:  r01_r    <= cfg_wdata[30:0];
        default:   ;
      endcase
    end
  end

  // pipeline registers
  stage_t st_r   [NST];
  stage_t st_nxt [NST];
  logic   adv;
  logic   skid_vld_r, out_vld_r;
  out_t   skid_r, out_r;
  out_t   last_res;

  // pipeline advances whenever the skid stage is free
  assign adv      = !skid_vld_r;
  assign in_ready = adv;

  always_comb begin
    logic [2:0][31:0] pa, pb;
    logic signed [34:0] v35, len35, w35;
    logic [63:0] bitc;
    logic [64:0] trial;
    logic [33:0] tdiv;
    logic [49:0] f;
    logic        neg;
    logic [31:0] kk;
    logic [30:0] rr0;
    logic        ksel;
    pa = {in_first_pos_z, in_first_pos_y, in_first_pos_x};
    pb = {in_second_pos_z, in_second_pos_y, in_second_pos_x};
    ksel = (int'(in_bond_kind) < BOND_KINDS) ? in_bond_kind[0] : 1'b0;

    // stage 0: capture, raw difference, index order filter
    st_nxt[0]      = st_r[0];
    st_nxt[0].vld  = in_valid && (in_first_index < in_second_index);
    st_nxt[0].kind = ksel;
    for (int a = 0; a < 3; a++) begin
      st_nxt[0].diff[a] = {{2{pa[a][31]}}, pa[a]} - {{2{pb[a][31]}}, pb[a]};
    end

    v35 = '0; len35 = '0; w35 = '0; bitc = '0; trial = '0; tdiv = '0;
    f = '0; neg = 1'b0; kk = '0; rr0 = '0;

    for (int j = 1; j < NST; j++) begin
      st_nxt[j] = st_r[j-1];
      if (j == 1) begin
        // minimum image wrap, once per axis, then clip
        for (int a = 0; a < 3; a++) begin
          v35   = {st_r[j-1].diff[a][33], st_r[j-1].diff[a]};
          len35 = $signed({4'b0, box_r[a]});
          if ((v35 <<< 1) > len35)       w35 = v35 - len35;
          else if ((v35 <<< 1) < -len35) w35 = v35 + len35;
          else                            w35 = v35;
          if (w35 > 35'sd2147483647)       st_nxt[j].d[a] = 32'h7fff_ffff;
          else if (w35 < -35'sd2147483648) st_nxt[j].d[a] = 32'h8000_0000;
          else                              st_nxt[j].d[a] = w35[31:0];
          st_nxt[j].mag[a] = st_nxt[j].d[a][31] ? (32'd0 - st_nxt[j].d[a])
                                                : st_nxt[j].d[a];
        end
      end else if (j == 2) begin
        for (int a = 0; a < 3; a++) begin
          st_nxt[j].sq[a] = st_r[j-1].mag[a] * st_r[j-1].mag[a];
        end
      end else if (j == 3) begin
        st_nxt[j].rem  = st_r[j-1].sq[0] + st_r[j-1].sq[1] + st_r[j-1].sq[2];
        st_nxt[j].root = '0;
      end else if (j >= SQ_FIRST && j < ERR_STG) begin
        // one digit of the integer square root
        bitc  = 64'd1 << (62 - 2 * (j - SQ_FIRST));
        trial = {1'b0, st_r[j-1].root} + {1'b0, bitc};
        if ({1'b0, st_r[j-1].rem} >= trial) begin
          st_nxt[j].rem  = st_r[j-1].rem - trial[63:0];
          st_nxt[j].root = (st_r[j-1].root >> 1) + bitc;
        end else begin
          st_nxt[j].root = st_r[j-1].root >> 1;
        end
      end else if (j == ERR_STG) begin
        rr0 = st_r[j-1].kind ? r01_r : r00_r;
        st_nxt[j].r    = st_r[j-1].root[31:0];
        st_nxt[j].eneg = st_nxt[j].r < {1'b0, rr0};
        st_nxt[j].eabs = st_nxt[j].eneg ? ({1'b0, rr0} - st_nxt[j].r)
                                        : (st_nxt[j].r - {1'b0, rr0});
        // integer quotient bit of mag / r, then fraction steps follow
        for (int a = 0; a < 3; a++) begin
          st_nxt[j].u[a] = '0;
          if (st_r[j-1].mag[a] >= st_nxt[j].r) begin
            st_nxt[j].u[a][32] = 1'b1;
            st_nxt[j].drem[a]  = {1'b0, st_r[j-1].mag[a] - st_nxt[j].r};
          end else begin
            st_nxt[j].drem[a]  = {1'b0, st_r[j-1].mag[a]};
          end
        end
      end else if (j >= DIV_FIRST && j < MUL_STG) begin
        if (j == DIV_FIRST) begin
          kk = st_r[j-1].kind ? k1_r : k0_r;
          st_nxt[j].prod = kk * st_r[j-1].eabs;
        end
        for (int a = 0; a < 3; a++) begin
          tdiv = {st_r[j-1].drem[a], 1'b0};
          if (tdiv >= {2'b0, st_r[j-1].r}) begin
            st_nxt[j].drem[a] = 33'(tdiv - {2'b0, st_r[j-1].r});
            st_nxt[j].u[a][31 - (j - DIV_FIRST)] = 1'b1;
          end else begin
            st_nxt[j].drem[a] = tdiv[32:0];
          end
        end
      end else if (j == MUL_STG) begin
        for (int a = 0; a < 3; a++) begin
          st_nxt[j].phi[a] = st_r[j-1].prod[63:48] * st_r[j-1].u[a];
          st_nxt[j].plo[a] = st_r[j-1].prod[47:16] * st_r[j-1].u[a];
        end
      end else begin
        // force sign, saturation, zero separation
        st_nxt[j].sat = 1'b0;
        st_nxt[j].zl  = (st_r[j-1].r == 32'd0);
        for (int a = 0; a < 3; a++) begin
          f   = {1'b0, st_r[j-1].phi[a]} + {17'b0, st_r[j-1].plo[a][64:32]};
          neg = (st_r[j-1].d[a] != 32'd0) && (f != 50'd0) &&
                ((!st_r[j-1].d[a][31]) != st_r[j-1].eneg);
          if (neg) begin
            if (f > 50'h8000_0000) begin
              st_nxt[j].frc[a] = 32'h8000_0000;
              st_nxt[j].sat    = 1'b1;
            end else begin
              st_nxt[j].frc[a] = 32'd0 - f[31:0];
            end
          end else begin
            if (f > 50'h7fff_ffff) begin
              st_nxt[j].frc[a] = 32'h7fff_ffff;
              st_nxt[j].sat    = 1'b1;
            end else begin
              st_nxt[j].frc[a] = f[31:0];
            end
          end
        end
        if (st_nxt[j].zl) begin
          st_nxt[j].frc = '0;
          st_nxt[j].sat = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) st_r[j].vld <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < NST; j++) st_r[j] <= st_nxt[j];
    end
  end

  // result leaving the last stage
  always_comb begin
    last_res.frc  = st_r[NST-1].frc;
    last_res.sep  = st_r[NST-1].d;
    last_res.rlen = st_r[NST-1].r;
    last_res.zl   = st_r[NST-1].zl;
    last_res.sat  = st_r[NST-1].sat;
  end

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_ready) begin
      if (adv && st_r[NST-1].vld) begin
        skid_vld_r <= 1'b1;
        skid_r     <= last_res;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      out_r      <= skid_r;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= st_r[NST-1].vld;
      out_r     <= last_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_force_x     = out_r.frc[0];
  assign out_force_y     = out_r.frc[1];
  assign out_force_z     = out_r.frc[2];
  assign out_sep_x       = out_r.sep[0];
  assign out_sep_y       = out_r.sep[1];
  assign out_sep_z       = out_r.sep[2];
  assign out_distance    = out_r.rlen;
  assign out_zero_length = out_r.zl;
  assign out_saturated   = out_r.sat;

  // the skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a beat with no output beat ahead");

  // taking a result with the skid full keeps the output valid
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && skid_vld_r) |=> out_vld_r)
    else $error("skid beat lost on drain");

  // out-of-order indices never enter the pipeline
  a_order_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_first_index >= in_second_index)) |=> !st_r[0].vld)
    else $error("bond with non-increasing indices entered the pipeline");

  // zero separation gives zero force and no clipping
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_zero_length) |->
      (out_force_x == 32'd0 && out_force_y == 32'd0 && out_force_z == 32'd0 &&
       !out_saturated))
    else $error("zero length result carries force");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: self-checking bench for the harmonic bond force unit with a built-in force predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hbf_pkg::*;

  // register index that maps to nothing, writes to it must be dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  // margin waited out after every queued bond and predicted force is done
  localparam int DRAIN_CYCLES = 120;
  // cycles without any beat before the run is declared hung
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [23:0] first_idx;
    logic [23:0] second_idx;
    logic [31:0] pos_a[3];
    logic [31:0] pos_b[3];
    logic        kind;
  } bond_t;

  typedef struct packed {
    logic [31:0] fx, fy, fz;
    logic [31:0] sx, sy, sz;
    logic [31:0] rlen;
    logic        zl;
    logic        sat;
  } bond_force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_first_index = '0;
  logic [23:0] in_second_index = '0;
  logic [31:0] in_first_pos_x = '0;
  logic [31:0] in_first_pos_y = '0;
  logic [31:0] in_first_pos_z = '0;
  logic [31:0] in_second_pos_x = '0;
  logic [31:0] in_second_pos_y = '0;
  logic [31:0] in_second_pos_z = '0;
  logic [0:0]  in_bond_kind = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_force_x, out_force_y, out_force_z;
  logic [31:0] out_sep_x, out_sep_y, out_sep_z;
  logic [31:0] out_distance;
  logic        out_zero_length;
  logic        out_saturated;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  harmonic_bond_force_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_first_pos_x  (in_first_pos_x),
    .in_first_pos_y  (in_first_pos_y),
    .in_first_pos_z  (in_first_pos_z),
    .in_second_pos_x (in_second_pos_x),
    .in_second_pos_y (in_second_pos_y),
    .in_second_pos_z (in_second_pos_z),
    .in_bond_kind    (in_bond_kind),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_force_x     (out_force_x),
    .out_force_y     (out_force_y),
    .out_force_z     (out_force_z),
    .out_sep_x       (out_sep_x),
    .out_sep_y       (out_sep_y),
    .out_sep_z       (out_sep_z),
    .out_distance    (out_distance),
    .out_zero_length (out_zero_length),
    .out_saturated   (out_saturated),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // local copy of the register file, kept in step with every write
  logic [63:0] box_len[3];
  logic [63:0] stiff[2];
  logic [63:0] rest_len[2];

  bond_t       bond_q[$];     // bonds waiting to be driven
  bond_force_t force_q[$];    // forces predicted, not yet seen at the output
  bond_t       cur_bond;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // integer square root, floor, on the 64-bit sum of squares
  function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
    logic [63:0] v, root, bitv;
    v = val;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // expected force for one bond; returns 0 when the index order drops it
  function automatic bit bond_force(input bond_t b, output bond_force_t res);
    longint      a, c, len, v;
    longint      d[3];
    logic [63:0] mag[3];
    logic [63:0] sum, r, k, r0, m, eabs, u, f;
    logic [31:0] frc[3];
    bit          eneg, neg, sat;
    res = '0;
    if (b.first_idx >= b.second_idx) return 0;
    k = stiff[b.kind];
    r0 = rest_len[b.kind];
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a = longint'($signed(b.pos_a[i]));
      c = longint'($signed(b.pos_b[i]));
      len = longint'(box_len[i]);
      v = a - c;
      // single minimum image fold per axis
      if (2 * v > len) v = v - len;
      else if (2 * v < -len) v = v + len;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      d[i] = v;
      mag[i] = (v < 0) ? 64'(-v) : 64'(v);
      sum = sum + mag[i] * mag[i];
    end
    r = floor_sqrt(sum);
    res.sx = d[0][31:0];
    res.sy = d[1][31:0];
    res.sz = d[2][31:0];
    res.rlen = r[31:0];
    if (r == 0) begin
      // coincident particles: no direction, force held at zero
      res.zl = 1'b1;
      return 1;
    end
    eneg = r < r0;
    eabs = eneg ? r0 - r : r - r0;
    m = (k * eabs) >> 16;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      u = (mag[i] << 32) / r;
      f = (m >> 32) * u + (((m & 64'hFFFF_FFFF) * u) >> 32);
      // restoring force points against the stretch
      neg = (d[i] != 0) && (f != 0) && ((d[i] > 0) != eneg);
      if (neg) begin
        if (f > (64'd1 << 31)) begin
          f = 64'd1 << 31;
          sat = 1'b1;
        end
        frc[i] = 32'(-f);
      end else begin
        if (f > 64'h7FFF_FFFF) begin
          f = 64'h7FFF_FFFF;
          sat = 1'b1;
        end
        frc[i] = f[31:0];
      end
    end
    res.fx = frc[0];
    res.fy = frc[1];
    res.fz = frc[2];
    res.sat = sat;
    return 1;
  endfunction

  // driver: one bond per beat, idles at random while the queue has work
  always @(posedge clk) begin
    bond_force_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && bond_force(cur_bond, res)) force_q = {force_q, res};
      if (bond_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_bond = bond_q.pop_front();
        in_valid        <= 1'b1;
        in_first_index  <= cur_bond.first_idx;
        in_second_index <= cur_bond.second_idx;
        in_first_pos_x  <= cur_bond.pos_a[0];
        in_first_pos_y  <= cur_bond.pos_a[1];
        in_first_pos_z  <= cur_bond.pos_a[2];
        in_second_pos_x <= cur_bond.pos_b[0];
        in_second_pos_y <= cur_bond.pos_b[1];
        in_second_pos_z <= cur_bond.pos_b[2];
        in_bond_kind    <= cur_bond.kind;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random backpressure, every result beat checked against the oldest prediction
  always @(posedge clk) begin
    bond_force_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        got = '{out_force_x, out_force_y, out_force_z, out_sep_x, out_sep_y, out_sep_z,
                out_distance, out_zero_length, out_saturated};
        if (force_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: %p", got);
        end else begin
          want = force_q.pop_front();
          if (got.fx != want.fx || got.fy != want.fy || got.fz != want.fz ||
              got.sx != want.sx || got.sy != want.sy || got.sz != want.sz ||
              got.rlen != want.rlen || got.zl != want.zl || got.sat != want.sat) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("force mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // watchdog: any beat or an empty pipeline resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we ||
        (bond_q.size() == 0 && force_q.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BOX_X: box_len[0] = {33'd0, val[30:0]};
      CFG_BOX_Y: box_len[1] = {33'd0, val[30:0]};
      CFG_BOX_Z: box_len[2] = {33'd0, val[30:0]};
      CFG_K0:    stiff[0] = {32'd0, val};
      CFG_R0_0:  rest_len[0] = {33'd0, val[30:0]};
      CFG_K1:    stiff[1] = {32'd0, val};
      CFG_R0_1:  rest_len[1] = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
                           input logic [31:0] k0, input logic [31:0] r00,
                           input logic [31:0] k1, input logic [31:0] r01);
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_BOX_Z, bz);
    write_reg(CFG_K0, k0);
    write_reg(CFG_R0_0, r00);
    write_reg(CFG_K1, k1);
    write_reg(CFG_R0_1, r01);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_bond(input logic [23:0] fi, input logic [23:0] si,
                          input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                          input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
                          input logic kd);
    bond_t b;
    b.first_idx = fi;
    b.second_idx = si;
    b.pos_a = '{ax, ay, az};
    b.pos_b = '{bx, by, bz};
    b.kind = kd;
    bond_q = {bond_q, b};
  endtask

  // offset between partners: none, near, box scale or anywhere
  function automatic logic [31:0] rand_offset();
    case ($urandom_range(5))
      0:       return 32'd0;
      1, 2:    return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
      3:       return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_bonds(input int count);
    logic [23:0] fi, si;
    logic [31:0] a[3];
    for (int n = 0; n < count; n++) begin
      fi = 24'($urandom);
      si = 24'($urandom);
      // mostly well-ordered pairs, the rest are random and dropped by the block when not ordered
      if ($urandom_range(99) < 80) begin
        if (fi == si) si = fi + 1'b1;
        if (fi > si) {fi, si} = {si, fi};
        if (si == 0) si = 24'd1;
      end
      for (int i = 0; i < 3; i++)
        a[i] = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(32'h0010_0000));
      add_bond(fi, si, a[0], a[1], a[2], a[0] - rand_offset(), a[1] - rand_offset(),
               a[2] - rand_offset(), 1'($urandom));
    end
  endtask

  // hold off until every queued bond is sent and every force has come back
  task automatic drain();
    while (bond_q.size() != 0 || in_valid || force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    box_len = '{64'd65536, 64'd65536, 64'd65536};
    stiff = '{64'd0, 64'd0};
    rest_len = '{64'd65536, 64'd65536};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // phase 0: a write to the unused index, then directed corners with a live spring
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_all(32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
              32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0003_0000);
    // index order: equal, reversed, extremes
    add_bond(24'd5, 24'd5, 32'h1_0000, 0, 0, 0, 0, 0, 1'b0);
    add_bond(24'd9, 24'd3, 32'h1_0000, 0, 0, 0, 0, 0, 1'b0);
    add_bond(24'hFF_FFFF, 24'd0, 32'h1_0000, 0, 0, 0, 0, 0, 1'b1);
    add_bond(24'd0, 24'hFF_FFFF, 32'h2_0000, 0, 0, 0, 0, 0, 1'b0);
    add_bond(24'hFF_FFFE, 24'hFF_FFFF, 0, 32'h2_0000, 0, 0, 0, 0, 1'b1);
    // coincident particles
    add_bond(24'd1, 24'd2, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_bond(24'd1, 24'd2, 0, 0, 0, 0, 0, 0, 1'b1);
    // compressed and stretched spring, both kinds, every sign
    add_bond(24'd1, 24'd2, 32'h0000_8000, 0, 0, 0, 0, 0, 1'b0);
    add_bond(24'd1, 24'd2, 0, 32'hFFFF_8000, 0, 0, 0, 0, 1'b1);
    add_bond(24'd1, 24'd2, 0, 0, 32'h0004_0000, 0, 0, 0, 1'b0);
    add_bond(24'd1, 24'd2, 32'hFFFD_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 0, 1'b1);
    // wrap across the box both ways
    add_bond(24'd3, 24'd4, 32'h0004_8000, 0, 0, 32'hFFFB_8000, 0, 0, 1'b0);
    add_bond(24'd3, 24'd4, 32'hFFFB_8000, 32'h0009_0000, 0, 32'h0004_8000, 0, 0, 1'b1);
    // exactly half a box: no fold
    add_bond(24'd3, 24'd4, 32'h0005_0000, 32'hFFFB_0000, 0, 0, 0, 0, 1'b0);
    // extreme positions, separation beyond 32 bits gets clipped
    add_bond(24'd6, 24'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_bond(24'd6, 24'd7, 32'h8000_0000, 32'h7FFF_FFFF, 0,
             32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1);
    add_bond(24'd6, 24'd7, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 1'b0);
    drain();

    // phase 1: small box, sender idling often
    send_idle_pct = 64;
    write_all(32'h0008_0000, 32'h0010_0000, 32'h0100_0000,
              32'h0010_0000, 32'h0001_8000, 32'h0000_0100, 32'h0000_4000);
    add_random_bonds(135);
    drain();

    // phase 2: tiny box, stiffest spring, zero rest length, receiver stalling
    send_idle_pct = 0;
    recv_stall_pct = 64;
    write_all(32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
              32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    add_random_bonds(135);
    drain();

    // phase 3: widest box, largest rest length, light idling on both sides
    send_idle_pct = 7;
    recv_stall_pct = 7;
    write_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    add_random_bonds(135);
    drain();

    // phase 4: zero box length disables the fold, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_UNUSED, 32'h0000_1234);
    write_all(32'h0000_0000, 32'h8000_0000, 32'h0003_0000,
              32'h0000_0001, 32'h0000_0001, 32'h0123_4567, 32'h0002_0000);
    add_random_bonds(135);
    drain();

    // phase 5: random register values, mixed idling
    send_idle_pct = 30;
    recv_stall_pct = 30;
    write_all($urandom, 32'($urandom_range(32'h0100_0000)), $urandom,
              $urandom, 32'($urandom_range(32'h0008_0000)), $urandom, $urandom);
    add_random_bonds(135);
    drain();

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
